// ----- design/assert_macros.svh -----
// Shared assertion helpers, clocked on clock and quiet during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge.
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/lsbbr_pkg.sv -----
package lsbbr_pkg;

   localparam int BYTE_BITS   = 8;
   localparam int WORD_BITS   = 64;
   localparam int COUNT_W     = 7;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 72;

   typedef logic [1:0]           req_kind_type;
   typedef logic [COUNT_W-1:0]   req_bits_type;
   typedef logic [BYTE_BITS-1:0] byte_type;
   typedef logic [WORD_BITS-1:0] word_type;

   // Request kinds carried on req_tuser
   localparam req_kind_type REQ_PUSH    = 2'd0;
   localparam req_kind_type REQ_PEEK    = 2'd1;
   localparam req_kind_type REQ_ADVANCE = 2'd2;
   localparam req_kind_type REQ_READ    = 2'd3;

endpackage

// ----- design/lsb_first_bit_reader_top.sv -----
// LSB-first bit reader over a byte queue.
// Request channel (req_*): one word per request. req_tuser selects push, peek,
// advance or read; req_tdata carries the byte to push and the bit count (0..64,
// larger counts act as 64). Response channel (rsp_*): exactly one word per
// request, in request order: the bits (first bit in bit 0), the available bit
// count reported by a peek or read, and an ok flag.
// Pipeline: an accepted request lands in the input register; at an edge where
// the result register is free or being taken, it is evaluated against the
// queue, updates the queue and loads the result register.
// Throughput is one request per cycle, back to back, while rsp_tready stays
// high, since every request finishes its state update when it is evaluated.
// The queue is a shift line of QUEUE_DEPTH bytes, oldest byte at entry 0; an
// advance or read drops up to 8 bytes in a single shift.
// Reset empties the queue and drops the partial byte; no clearing pass is needed.
// When rsp_tready is low the result holds; the input register still takes one
// more request, after which req_tready falls until the result is taken.
`include "assert_macros.svh"

module lsb_first_bit_reader_top
   import lsbbr_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [7:0] data_byte, [14:8] req_bits, [15] zero
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [63:0] value, [70:64] avail_bits, [71] ok
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);  // holds 0..QUEUE_DEPTH
   localparam int TW = CW + 4;                   // total buffered bits

   // ---------------------------------------------------------------- state
   logic [CW-1:0] count_ff, count_in;
   logic          pvalid_ff, pvalid_in;
   byte_type      partial_ff, partial_in;
   logic [3:0]    cursor_ff, cursor_in;          // 0..8, 8 = partial byte used up
   byte_type      queue_ff  [QUEUE_DEPTH];
   byte_type      queue_in  [QUEUE_DEPTH];
   byte_type      queue_ext [QUEUE_DEPTH + 8];   // queue plus zero tail for the shift

   // input register
   logic          s1_valid_ff, s1_valid_in;
   req_kind_type  s1_kind_ff;
   byte_type      s1_byte_ff;
   req_bits_type  s1_count_ff;
   req_bits_type  count_clamped;

   // result register
   logic          out_valid_ff, out_valid_in;
   word_type      out_value_ff;
   req_bits_type  out_avail_ff;
   logic          out_ok_ff;

   // handshake
   logic out_free, fire, req_take;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign fire       = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   assign s1_valid_in  = req_tready ? req_tvalid : s1_valid_ff;
   assign out_valid_in = out_free ? fire : 1'b1;

   assign count_clamped = (req_tdata[14:8] > COUNT_W'(WORD_BITS)) ?
                          COUNT_W'(WORD_BITS) : req_tdata[14:8];

   // ---------------------------------------------------------------- peek
   logic [3:0]    want_bytes, fifo_bytes, min_bytes, k_bytes, partial_off;
   word_type      head_word, kept_word, merged_word, low_mask;
   byte_type      partial_bits;
   logic [7:0]    sum_bits;
   logic          partial_fit;
   req_bits_type  peek_avail;
   word_type      peek_value;
   logic          peek_ok;

   always_comb begin
      priority if (s1_count_ff <= 7'd8) begin
         want_bytes = 4'd1;
      end else if (s1_count_ff <= 7'd16) begin
         want_bytes = 4'd2;
      end else if (s1_count_ff <= 7'd32) begin
         want_bytes = 4'd4;
      end else begin
         want_bytes = 4'd8;
      end
   end

   assign fifo_bytes = (count_ff >= CW'(8)) ? 4'd8 : count_ff[3:0];
   assign min_bytes  = (want_bytes < fifo_bytes) ? want_bytes : fifo_bytes;

   // largest power of two not above min_bytes
   always_comb begin
      priority if (min_bytes >= 4'd8) begin
         k_bytes = 4'd8;
      end else if (min_bytes >= 4'd4) begin
         k_bytes = 4'd4;
      end else if (min_bytes >= 4'd2) begin
         k_bytes = 4'd2;
      end else if (min_bytes >= 4'd1) begin
         k_bytes = 4'd1;
      end else begin
         k_bytes = 4'd0;
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) begin
         head_word[8*i +: 8] = queue_ff[i];
         kept_word[8*i +: 8] = (4'(i) < k_bytes) ? queue_ff[i] : 8'h00;
      end
   end

   assign partial_off  = pvalid_ff ? (4'd8 - cursor_ff) : 4'd0;
   assign partial_bits = partial_ff >> cursor_ff;   // cursor of 8 leaves nothing
   assign merged_word  = (kept_word << partial_off) |
                         (pvalid_ff ? {56'd0, partial_bits} : '0);
   assign low_mask     = ~({WORD_BITS{1'b1}} << s1_count_ff);  // 64 gives all ones
   assign sum_bits     = {1'b0, k_bytes, 3'b000} + {4'd0, partial_off};
   assign partial_fit  = pvalid_ff && ({3'd0, partial_off} >= s1_count_ff);

   always_comb begin
      if (k_bytes == 4'd0) begin
         // queue empty: only the partial byte counts, and only if it covers the request
         peek_avail = partial_fit ? {3'd0, partial_off} : '0;
         peek_value = partial_fit ? (merged_word & low_mask) : '0;
      end else begin
         peek_avail = (sum_bits > 8'd64) ? COUNT_W'(WORD_BITS) : sum_bits[6:0];
         peek_value = merged_word & low_mask;
      end
   end

   assign peek_ok = peek_avail >= s1_count_ff;

   // ---------------------------------------------------------------- advance
   logic [TW-1:0] total_bits;
   logic          adv_ok, push_ok, do_advance, do_push;
   req_bits_type  past_partial;
   logic [3:0]    whole_bytes, pop_bytes, pop_cnt;
   logic [2:0]    rem_bits;
   byte_type      tail_byte;

   assign total_bits   = TW'({count_ff, 3'b000}) + TW'(partial_off);
   assign adv_ok       = TW'(s1_count_ff) <= total_bits;
   assign past_partial = s1_count_ff - {3'd0, partial_off};
   assign whole_bytes  = past_partial[6:3];
   assign rem_bits     = past_partial[2:0];
   assign pop_bytes    = whole_bytes + {3'd0, (rem_bits != 3'd0)};
   assign tail_byte    = head_word[{whole_bytes[2:0], 3'b000} +: 8];
   assign push_ok      = count_ff < CW'(QUEUE_DEPTH);

   assign do_push    = fire && (s1_kind_ff == REQ_PUSH) && push_ok;
   assign do_advance = fire && (((s1_kind_ff == REQ_ADVANCE) && adv_ok) ||
                                ((s1_kind_ff == REQ_READ) && peek_ok));
   assign pop_cnt    = (do_advance && !partial_fit) ? pop_bytes : 4'd0;

   always_comb begin
      count_in   = count_ff;
      pvalid_in  = pvalid_ff;
      partial_in = partial_ff;
      cursor_in  = cursor_ff;
      if (do_push) begin
         count_in = count_ff + CW'(1);
      end else if (do_advance) begin
         if (partial_fit) begin
            cursor_in = cursor_ff + s1_count_ff[3:0];
         end else begin
            count_in = count_ff - CW'(pop_bytes);
            if (rem_bits == 3'd0) begin
               pvalid_in = 1'b0;
            end else begin
               pvalid_in  = 1'b1;
               partial_in = tail_byte;
               cursor_in  = {1'b0, rem_bits};
            end
         end
      end
   end

   // shift line: entry i takes entry i+pop_cnt, a push writes at the fill point
   for (genvar g = 0; g < QUEUE_DEPTH + 8; g++) begin : g_ext
      if (g < QUEUE_DEPTH) begin : g_live
         assign queue_ext[g] = queue_ff[g];
      end else begin : g_pad
         assign queue_ext[g] = 8'h00;
      end
   end

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         queue_in[i] = queue_ff[i];
         for (int j = 1; j <= 8; j++) begin
            if (pop_cnt == 4'(j)) begin
               queue_in[i] = queue_ext[i + j];
            end
         end
         if (do_push && (count_ff == CW'(i))) begin
            queue_in[i] = s1_byte_ff;
         end
      end
   end

   // ---------------------------------------------------------------- result
   word_type      res_value;
   req_bits_type  res_avail;
   logic          res_ok;

   always_comb begin
      unique case (s1_kind_ff)
         REQ_PUSH: begin
            res_value = '0;
            res_avail = '0;
            res_ok    = push_ok;
         end
         REQ_PEEK: begin
            res_value = peek_value;
            res_avail = peek_avail;
            res_ok    = peek_ok;
         end
         REQ_ADVANCE: begin
            res_value = '0;
            res_avail = '0;
            res_ok    = adv_ok;
         end
         REQ_READ: begin
            res_value = peek_ok ? peek_value : '0;
            res_avail = peek_avail;
            res_ok    = peek_ok;
         end
         default: begin
            res_value = '0;
            res_avail = '0;
            res_ok    = 1'b0;
         end
      endcase
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ok_ff, out_avail_ff, out_value_ff};

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         count_ff     <= '0;
         pvalid_ff    <= 1'b0;
         partial_ff   <= '0;
         cursor_ff    <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         count_ff     <= count_in;
         pvalid_ff    <= pvalid_in;
         partial_ff   <= partial_in;
         cursor_ff    <= cursor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_kind_ff  <= req_tuser;
         s1_byte_ff  <= req_tdata[7:0];
         s1_count_ff <= count_clamped;
      end
      if (fire) begin
         out_value_ff <= res_value;
         out_avail_ff <= res_avail;
         out_ok_ff    <= res_ok;
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         queue_ff[i] <= queue_in[i];
      end
   end

   // ---------------------------------------------------------------- checks
   `ASSERT_ALWAYS(a_count_bound, count_ff <= CW'(QUEUE_DEPTH), "queue count above depth")
   `ASSERT_ALWAYS(a_cursor_bound, cursor_ff <= 4'd8, "bit cursor past end of byte")
   `ASSERT_NEXT(a_refused_holds, fire && !do_advance && !do_push, $stable(count_ff) && $stable(pvalid_ff) && $stable(cursor_ff), "state moved on a request that changes nothing")
   `ASSERT_NEXT(a_push_grows, do_push, count_ff == $past(count_ff) + CW'(1), "push did not grow the queue")
   `ASSERT_NEXT(a_result_loaded, fire, rsp_tvalid, "evaluated request left no result")

endmodule
